// ===== design/b58_pkg.sv =====
// ----------------------------------------------------------------------------
// b58_pkg: shared definitions for the Base58 encoder
// Alphabet, per-digit multiply-by-256 tables, control/status bundles.
// ----------------------------------------------------------------------------
package b58_pkg;

    localparam int MAX_BYTES_DEF = 32;
    localparam int MAX_RESULTS   = 45;
    localparam int RES_W         = $clog2(MAX_RESULTS + 1);
    localparam int B58           = 58;
    localparam int DIG_W         = 6;
    localparam int BYTE_W        = 8;
    localparam int TAB_N         = 2 ** DIG_W;
    localparam int Q256          = 256 / B58;
    localparam int R256          = 256 % B58;

    localparam logic [7:0] CHAR_ONE  = 8'h31;
    localparam logic [7:0] CHAR_NONE = 8'h00;

    typedef logic [7:0] t_char;
    typedef logic [TAB_N-1:0][BYTE_W-1:0] t_qtab;
    typedef logic [TAB_N-1:0][DIG_W-1:0]  t_rtab;

    localparam t_char ALPHA [B58] = '{
        "1", "2", "3", "4", "5", "6", "7", "8", "9",
        "A", "B", "C", "D", "E", "F", "G", "H", "J", "K", "L", "M", "N",
        "P", "Q", "R", "S", "T", "U", "V", "W", "X", "Y", "Z",
        "a", "b", "c", "d", "e", "f", "g", "h", "i", "j", "k", "m", "n",
        "o", "p", "q", "r", "s", "t", "u", "v", "w", "x", "y", "z"
    };

    // quotient of d*256 by 58, built by stepping d (elaboration only)
    function automatic t_qtab build_qtab();
        t_qtab t;
        int    q;
        int    r;
        int    d;
        t = '0;
        q = 0;
        r = 0;
        for (d = 0; d < TAB_N; d++) begin
            t[d] = BYTE_W'(q);
            q = q + Q256;
            r = r + R256;
            if (r >= B58) begin
                r = r - B58;
                q = q + 1;
            end
        end
        return t;
    endfunction

    // remainder of d*256 by 58
    function automatic t_rtab build_rtab();
        t_rtab t;
        int    r;
        int    d;
        t = '0;
        r = 0;
        for (d = 0; d < TAB_N; d++) begin
            t[d] = DIG_W'(r);
            r = r + R256;
            if (r >= B58) begin
                r = r - B58;
            end
        end
        return t;
    endfunction

    localparam t_qtab MULQ = build_qtab();
    localparam t_rtab MULR = build_rtab();

    // map one base-58 digit to its character; fold codes above 57
    function automatic t_char b58_char(input logic [DIG_W-1:0] d);
        logic [DIG_W-1:0] k;
        k = (d >= DIG_W'(B58)) ? d - DIG_W'(B58) : d;
        return ALPHA[k];
    endfunction

    typedef struct packed {
        logic accept;   // input item taken
        logic sweep;    // one digit of the multiply-add sweep
        logic prep;     // set up emission counters
        logic fetch;    // read the next digit
        logic load;     // load one character into the output register
        logic err;      // load the too-long result
        logic clear;    // drop message state
    } t_cmd;

    typedef struct packed {
        logic full;         // byte would exceed the limit
        logic sweep_last;   // sweep is at the top digit
        logic remain_zero;  // nothing left to emit
    } t_stat;

endpackage

// ===== design/b58_if.sv =====
// ----------------------------------------------------------------------------
// b58_if: valid/ready channels of the Base58 encoder
// Input byte channel and output character channel.
// ----------------------------------------------------------------------------
interface b58_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_message;

    modport source (output valid, output data_byte, output end_of_message, input ready);
    modport sink   (input valid, input data_byte, input end_of_message, output ready);
endinterface

interface b58_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       last_char;
    logic       too_long;

    modport source (output valid, output char_code, output last_char, output too_long,
                    input ready);
    modport sink   (input valid, input char_code, input last_char, input too_long,
                    output ready);
endinterface

// ===== design/b58_ctrl.sv =====
// ----------------------------------------------------------------------------
// b58_ctrl: Base58 encoder controller
// Sequences byte intake, digit sweep and character emission.
// ----------------------------------------------------------------------------
module b58_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_eom,
    input  logic           i_out_ready,
    input  b58_pkg::t_stat i_stat,
    output b58_pkg::t_cmd  o_cmd,
    output logic           o_in_ready,
    output logic           o_out_valid
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SWEEP = 7'b0000010,
        S_PREP  = 7'b0000100,
        S_FETCH = 7'b0001000,
        S_LOAD  = 7'b0010000,
        S_ERR   = 7'b0100000,
        S_WAIT  = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_eom;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_stat.full) begin
                        n_state = i_eom ? S_ERR : S_IDLE;
                    end else begin
                        n_state = S_SWEEP;
                    end
                end
            end
            S_SWEEP: begin
                o_cmd.sweep = 1'b1;
                if (i_stat.sweep_last) begin
                    n_state = r_eom ? S_PREP : S_IDLE;
                end
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = S_FETCH;
            end
            S_FETCH: begin
                if (i_stat.remain_zero) begin
                    o_cmd.clear = 1'b1;
                    n_state     = S_IDLE;
                end else begin
                    o_cmd.fetch = 1'b1;
                    n_state     = S_LOAD;
                end
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
                n_state    = S_WAIT;
            end
            S_ERR: begin
                o_cmd.err = 1'b1;
                n_state   = S_WAIT;
            end
            S_WAIT: begin
                if (i_out_ready) begin
                    n_state = S_FETCH;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd.accept) begin
            r_eom <= i_eom;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_WAIT);

endmodule

// ===== design/b58_dpath.sv =====
// ----------------------------------------------------------------------------
// b58_dpath: Base58 encoder datapath
// Digit memory, multiply-by-256 sweep unit, counters and output register.
// ----------------------------------------------------------------------------
module b58_dpath #(
    parameter int MAX_BYTES = b58_pkg::MAX_BYTES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  b58_pkg::t_cmd               i_cmd,
    input  logic [b58_pkg::BYTE_W-1:0]  i_byte,
    output b58_pkg::t_stat              o_stat,
    output logic [7:0]                  o_char,
    output logic                        o_last,
    output logic                        o_err
);

    localparam int DIGITS = MAX_BYTES * 138 / 100 + 1;
    localparam int AW     = $clog2(DIGITS);
    localparam int TW     = $clog2(DIGITS + 1);
    localparam int CW     = $clog2(MAX_BYTES + 1);
    localparam int MW     = (TW > CW) ? ((TW > b58_pkg::RES_W) ? TW : b58_pkg::RES_W)
                                      : ((CW > b58_pkg::RES_W) ? CW : b58_pkg::RES_W);
    localparam int SW     = MW + 1;
    localparam int DW     = b58_pkg::DIG_W;
    localparam int BW     = b58_pkg::BYTE_W;
    localparam int RW     = b58_pkg::RES_W;

    // digit store, digit 0 least significant; valid bit per digit
    logic [DW-1:0]     mem [DIGITS];
    logic [DIGITS-1:0] r_vld;
    logic [DW-1:0]     r_rd_data;
    logic              r_rd_vld;

    logic [AW-1:0] r_idx;
    logic [BW-1:0] r_carry;
    logic [TW-1:0] r_top;
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] r_lz;
    logic          r_seen;
    logic          r_ovf;
    logic [CW-1:0] r_zleft;
    logic [TW-1:0] r_dptr;
    logic [RW-1:0] r_remain;

    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [DW-1:0] d_cur;
    logic [8:0]    s;
    logic [2:0]    q_s;
    logic [8:0]    r_s;
    logic [BW-1:0] carry_n;
    logic [DW-1:0] dig_n;
    logic [SW-1:0] total;

    // read port address
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = '0;
        if (i_cmd.accept) begin
            rd_en = 1'b1;
        end else if (i_cmd.sweep) begin
            rd_en   = (r_idx != AW'(DIGITS - 1));
            rd_addr = AW'(r_idx + 1'b1);
        end else if (i_cmd.fetch) begin
            rd_en   = (r_zleft == '0);
            rd_addr = AW'(r_dptr - 1'b1);
        end
    end

    // one digit of (buffer * 256 + carry): table split, then fold by 58
    assign d_cur = r_rd_vld ? r_rd_data : '0;
    assign s     = 9'(b58_pkg::MULR[d_cur]) + 9'(r_carry);
    assign q_s   = 3'(s >= 9'(b58_pkg::B58))     + 3'(s >= 9'(2 * b58_pkg::B58))
                 + 3'(s >= 9'(3 * b58_pkg::B58)) + 3'(s >= 9'(4 * b58_pkg::B58))
                 + 3'(s >= 9'(5 * b58_pkg::B58));

    always_comb begin
        case (q_s)
            3'd0:    r_s = s;
            3'd1:    r_s = s - 9'(b58_pkg::B58);
            3'd2:    r_s = s - 9'(2 * b58_pkg::B58);
            3'd3:    r_s = s - 9'(3 * b58_pkg::B58);
            3'd4:    r_s = s - 9'(4 * b58_pkg::B58);
            default: r_s = s - 9'(5 * b58_pkg::B58);
        endcase
    end

    assign carry_n = b58_pkg::MULQ[d_cur] + BW'(q_s);
    assign dig_n   = r_s[DW-1:0];
    assign total   = SW'(r_lz) + SW'(r_top);

    always_ff @(posedge i_clk) begin
        if (i_cmd.sweep) begin
            mem[r_idx] <= dig_n;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
            r_rd_vld  <= r_vld[rd_addr];
        end
    end

    // message state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_vld  <= '0;
            r_cnt  <= '0;
            r_lz   <= '0;
            r_seen <= 1'b0;
            r_ovf  <= 1'b0;
            r_top  <= '0;
        end else begin
            if (i_cmd.accept) begin
                if (o_stat.full) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                    r_top <= '0;
                    if (i_byte == '0 && !r_seen) begin
                        r_lz <= r_lz + 1'b1;
                    end else begin
                        r_seen <= 1'b1;
                    end
                end
            end
            if (i_cmd.sweep) begin
                r_vld[r_idx] <= 1'b1;
                if (dig_n != '0) begin
                    r_top <= TW'(r_idx) + 1'b1;
                end
            end
        end
    end

    // sweep and emission counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx    <= '0;
            r_zleft  <= '0;
            r_dptr   <= '0;
            r_remain <= '0;
        end else begin
            if (i_cmd.accept) begin
                r_idx <= '0;
            end else if (i_cmd.sweep) begin
                r_idx <= AW'(r_idx + 1'b1);
            end
            if (i_cmd.prep) begin
                r_zleft  <= r_lz;
                r_dptr   <= r_top;
                r_remain <= (total > SW'(b58_pkg::MAX_RESULTS)) ? RW'(b58_pkg::MAX_RESULTS)
                                                                 : RW'(total);
            end else if (i_cmd.load) begin
                r_remain <= r_remain - 1'b1;
                if (r_zleft != '0) begin
                    r_zleft <= r_zleft - 1'b1;
                end else begin
                    r_dptr <= r_dptr - 1'b1;
                end
            end else if (i_cmd.err) begin
                r_remain <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_carry <= i_byte;
        end else if (i_cmd.sweep) begin
            r_carry <= carry_n;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            o_char <= (r_zleft != '0) ? b58_pkg::CHAR_ONE : b58_pkg::b58_char(d_cur);
            o_last <= (r_remain == RW'(1));
            o_err  <= 1'b0;
        end else if (i_cmd.err) begin
            o_char <= b58_pkg::CHAR_NONE;
            o_last <= 1'b0;
            o_err  <= 1'b1;
        end
    end

    assign o_stat.full        = r_ovf || (r_cnt >= CW'(MAX_BYTES));
    assign o_stat.sweep_last  = (r_idx == AW'(DIGITS - 1));
    assign o_stat.remain_zero = (r_remain == '0);

endmodule

// ===== design/base58_encoder.sv =====
// Sequencing: each accepted byte is followed by the digit sweep, one base-58 digit
//   per cycle through the memory's read and write ports; no new byte is taken meanwhile.
// On the final byte a prep step follows the sweep, then fetch, load and a wait for the
//   output to be taken for each character, then a clear step.
// Reset: synchronous, active low; clears the controller and all digit valid bits at
//   once, so the block accepts a byte in the first cycle after reset.
// ----------------------------------------------------------------------------
// base58_encoder: streaming Base58 encoder
// Absorbs a message one byte per item into a base-58 digit store and, on the
// final byte, emits the encoded characters one item each.
// ----------------------------------------------------------------------------
module base58_encoder #(
    parameter int MAX_BYTES = b58_pkg::MAX_BYTES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    b58_in_if.sink           i_in,
    b58_out_if.source        o_out
);

    // Controller to datapath command bundle and status back.
    b58_pkg::t_cmd  w_cmd;
    b58_pkg::t_stat w_stat;
    logic           w_in_ready;
    logic           w_out_valid;

    // Controller: intake in idle, then the digit sweep, then one character at a
    // time through the output register. Leading zero bytes come out as '1' first,
    // then digits from the most significant nonzero one down, capped at the
    // result limit. An overlong message yields a single too-long item.
    b58_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_eom       (i_in.end_of_message),
        .i_out_ready (o_out.ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid)
    );

    // Datapath: digit memory with registered read, multiply-by-256 sweep unit
    // built from a per-digit table and a fold by 58, byte/zero counters, and the
    // registered character output.
    b58_dpath #(
        .MAX_BYTES (MAX_BYTES)
    ) u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_byte  (i_in.data_byte),
        .o_stat  (w_stat),
        .o_char  (o_out.char_code),
        .o_last  (o_out.last_char),
        .o_err   (o_out.too_long)
    );

    // Handshakes: input only in idle, output only while a character is held.
    assign i_in.ready  = w_in_ready;
    assign o_out.valid = w_out_valid;

    // A held result and input intake never overlap.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !i_in.ready)
        else $error("input ready while a result is held");

    // An absorbed byte starts a sweep: no new byte in the next cycle.
    a_sweep_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && !w_stat.full) |=> !i_in.ready)
        else $error("byte accepted during digit sweep");

    // A taken character is not shown again in the next cycle.
    a_one_shot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready) |=> !o_out.valid)
        else $error("result repeated after being taken");

endmodule
